@@ sv/huffman_code_bit_packer_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the code bit packer.
// Each macro checks a property on the rising edge of clk, outside reset.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_MACROS_SVH

// A property that holds at every clock edge.
`define HCBP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that implies another in the next cycle.
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/hcbp_pkg.sv @@
// ---------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the code bit packer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int NUM_SYMBOLS  = 256;
	localparam int BYTE_BITS    = 8;
	localparam int TABLE_DEPTH  = 256;
	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int LEN_LIMIT    = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
	localparam int PEND_W       = BYTE_BITS - 1;
	localparam int ACC_W        = LEN_LIMIT + PEND_W;
	localparam int TOT_W        = $clog2(ACC_W + 1);
	localparam int MAX_RESULTS  = ACC_W / BYTE_BITS;
	localparam int NCNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH  = 8;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_word;
		logic [LEN_W-1:0]  code_length;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic [2:0]           pad_bits;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_rd_t;

	typedef struct packed {
		logic [NCNT_W-1:0]                n;
		out_item_t [MAX_RESULTS-1:0]      item;
	} push_t;

endpackage

@@ sv/hcbp_table.sv @@
// ---------------------------------------------------------------------------
// hcbp_table
// Code table: one synchronous memory of code words and lengths, with a
// valid bit per entry so that an unwritten entry reads as length zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  hcbp_pkg::in_item_t item,
	output hcbp_pkg::tbl_rd_t rd
);
	import hcbp_pkg::*;

	logic [CODE_W+LEN_W-1:0] mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]  vld_q;
	logic [CODE_W+LEN_W-1:0] rd_q;
	logic                    rd_vld_q;
	logic                    in_range;
	logic                    wr_en;
	logic [LEN_W-1:0]        len_sat;

	assign in_range = {1'b0, item.symbol} < (SYM_W + 1)'(NUM_SYMBOLS);
	assign wr_en    = accept && (item.opcode == OP_LOAD) && in_range;
	assign len_sat  = (item.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
	                                                         : item.code_length;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[item.symbol] <= {item.code_word, len_sat};
		end
		if (accept) begin
			rd_q <= mem[item.symbol];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[item.symbol] <= 1'b1;
			end
			if (accept) begin
				rd_vld_q <= vld_q[item.symbol] && in_range;
			end
		end
	end

	assign rd.code = rd_q[CODE_W+LEN_W-1:LEN_W];
	assign rd.len  = rd_vld_q ? rd_q[LEN_W-1:0] : '0;

endmodule

@@ sv/hcbp_pack.sv @@
// ---------------------------------------------------------------------------
// hcbp_pack
// Bit accumulator stage: merges the looked-up code with the leftover bits,
// splits off every full byte and handles the final padded byte on flush.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        opcode,
	input  hcbp_pkg::tbl_rd_t rd,
	output hcbp_pkg::push_t   push
);
	import hcbp_pkg::*;

	logic              v_s1;
	logic [1:0]        op_s1;
	logic [PEND_W-1:0] pend_q;
	logic [2:0]        pcnt_q;
	logic [PEND_W-1:0] pend_d;
	logic [2:0]        pcnt_d;
	logic [ACC_W-1:0]  code_x;
	logic [ACC_W-1:0]  acc;
	logic [ACC_W-1:0]  al;
	logic [TOT_W-1:0]  total;
	logic [2:0]        pad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			op_s1  <= OP_LOAD;
			pend_q <= '0;
			pcnt_q <= '0;
		end else begin
			v_s1   <= accept;
			op_s1  <= opcode;
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
		end
	end

	always_comb begin
		code_x = ACC_W'(rd.code) & ((ACC_W'(1) << rd.len) - ACC_W'(1));
		acc    = (ACC_W'(pend_q) << rd.len) | code_x;
		total  = TOT_W'(pcnt_q) + TOT_W'(rd.len);
		al     = acc << (TOT_W'(ACC_W) - total);
		pad    = 3'(4'(BYTE_BITS) - {1'b0, pcnt_q});

		pend_d = pend_q;
		pcnt_d = pcnt_q;
		push   = '0;

		if (v_s1) begin
			case (op_s1)
				OP_ENCODE: begin
					if (rd.len != '0) begin
						push.n = NCNT_W'(total >> 3);
						for (int k = 0; k < MAX_RESULTS; k++) begin
							push.item[k].out_byte = al[ACC_W-1-BYTE_BITS*k -: BYTE_BITS];
						end
						pend_d = acc[PEND_W-1:0] &
						         ((PEND_W'(1) << total[2:0]) - PEND_W'(1));
						pcnt_d = total[2:0];
					end
				end
				OP_FLUSH: begin
					if (pcnt_q != '0) begin
						push.n                = NCNT_W'(1);
						push.item[0].out_byte = {1'b0, pend_q} << pad;
						push.item[0].pad_bits = pad;
						push.item[0].last     = 1'b1;
						pend_d                = '0;
						pcnt_d                = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ sv/hcbp_outq.sv @@
// ---------------------------------------------------------------------------
// hcbp_outq
// Output queue: takes up to four bytes per cycle from the accumulator stage
// and presents them one transaction at a time on the result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "huffman_code_bit_packer_top_macros.svh"

module hcbp_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  hcbp_pkg::push_t     push,
	output logic                room,
	output logic                result_valid,
	input  logic                result_stall,
	output hcbp_pkg::out_item_t result
);
	import hcbp_pkg::*;

	out_item_t          fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  head_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               pop;
	logic               pop_only;
	logic [QPTR_W-1:0]  tail;
	logic [QCNT_W:0]    fill;

	assign pop          = result_valid && !result_stall;
	assign pop_only     = pop && (push.n == '0);
	assign tail         = head_q + cnt_q[QPTR_W-1:0];
	assign result_valid = cnt_q != '0;
	assign result       = fifo_q[head_q];
	assign fill         = (QCNT_W + 1)'(cnt_q) + (QCNT_W + 1)'(push.n);
	assign room         = fill <= (QCNT_W + 1)'(QUEUE_DEPTH - MAX_RESULTS);

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (NCNT_W'(k) < push.n) begin
				fifo_q[tail + QPTR_W'(k)] <= push.item[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

	`HCBP_ASSERT(a_cnt_range, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
	`HCBP_ASSERT(a_no_overflow, fill <= (QCNT_W + 1)'(QUEUE_DEPTH), "queue overflow")
	`HCBP_ASSERT_NEXT(a_pop_only, pop_only, cnt_q == $past(cnt_q) - QCNT_W'(1), "count missed a pop")

endmodule

@@ sv/huffman_code_bit_packer_top.sv @@
// ---------------------------------------------------------------------------
// huffman_code_bit_packer_top
// The table read and the output queue are both registered between an item's
// accept and the offer of its first byte on the result channel.
// Throughput: one item per cycle while the output queue has room for four
// more bytes; bytes leave the output queue port one per cycle unless stalled.
// Reset clears the table valid bits, the leftover bits and the queue at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  hcbp_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output hcbp_pkg::out_item_t result
);
	import hcbp_pkg::*;

	logic    accept;
	logic    room;
	tbl_rd_t rd;
	push_t   push;

	assign item_stall = !room;
	assign accept     = item_valid && room;

	hcbp_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.rd     (rd)
	);

	hcbp_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.opcode (item.opcode),
		.rd     (rd),
		.push   (push)
	);

	hcbp_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
